>>> rtl/core/adcdi_pkg.sv
// Shared constants and types for the ADC deinterleave and CV averaging block.
package adcdi_pkg;

    localparam int ADC_W          = 14;
    localparam int AUDIO_W        = 16;
    localparam int CV_W           = 12;
    localparam int GAIN_W         = 9;
    localparam int GAIN_SHIFT     = 8;
    localparam int DEFAULT_FRAMES = 32;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 9'd261;
    localparam logic [CV_W-1:0]    CV_FULL    = 12'hfff;
    localparam logic [AUDIO_W-1:0] AUDIO_FLIP = 16'h8000;

    // Register word indexes on the configuration port.
    localparam logic REG_CV_GAIN = 1'b0;

    // Slot codes; the same codes travel as the result kind.
    typedef enum logic [1:0] {
        KIND_LEFT  = 2'd0,
        KIND_RIGHT = 2'd1,
        KIND_CV0   = 2'd2,
        KIND_CV1   = 2'd3
    } t_kind;

    typedef struct packed {
        logic               is_cv;
        t_kind              kind;
        logic [AUDIO_W-1:0] audio;
    } t_item;

    typedef struct packed {
        t_item           item;
        logic [CV_W-1:0] cv0;
        logic [CV_W-1:0] cv1;
    } t_pair;

endpackage

>>> rtl/core/adcdi_front.sv
// Slot tracking, audio conversion and CV block accumulation.
module adcdi_front #(
    parameter int FRAMES_PER_BLOCK = adcdi_pkg::DEFAULT_FRAMES,
    parameter int SUM_W            = adcdi_pkg::ADC_W + $clog2(FRAMES_PER_BLOCK)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [adcdi_pkg::ADC_W-1:0] i_sample,
    output logic                      o_ready,
    output logic                      o_valid,
    output adcdi_pkg::t_item          o_item,
    output logic [SUM_W-1:0]          o_sum0,
    output logic [SUM_W-1:0]          o_sum1,
    input  logic                      i_ready
);
    import adcdi_pkg::*;

    localparam int FRAME_L = $clog2(FRAMES_PER_BLOCK);
    localparam int FW      = (FRAME_L > 0) ? FRAME_L : 1;
    localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES_PER_BLOCK - 1);

    t_kind             r_slot, n_slot;
    logic [FW-1:0]     r_frame, n_frame;
    logic [SUM_W-1:0]  r_cv0_sum, n_cv0_sum;
    logic [SUM_W-1:0]  r_cv1_sum, n_cv1_sum;
    logic              r_valid, n_valid;
    t_item             r_item, n_item;
    logic [SUM_W-1:0]  r_sum0, n_sum0;
    logic [SUM_W-1:0]  r_sum1, n_sum1;
    logic              accept;
    logic [SUM_W-1:0]  sample_ext;

    assign o_ready    = !r_valid || i_ready;
    assign accept     = i_valid && o_ready;
    assign sample_ext = SUM_W'(i_sample);

    always_comb begin
        n_slot    = r_slot;
        n_frame   = r_frame;
        n_cv0_sum = r_cv0_sum;
        n_cv1_sum = r_cv1_sum;
        n_valid   = r_valid && !i_ready;
        n_item    = r_item;
        n_sum0    = r_sum0;
        n_sum1    = r_sum1;
        if (accept) begin
            n_slot       = t_kind'(r_slot + 2'd1);
            n_item.is_cv = 1'b0;
            n_item.kind  = r_slot;
            n_item.audio = {i_sample, 2'b00} ^ AUDIO_FLIP;
            n_valid      = 1'b0;
            unique case (r_slot)
                KIND_LEFT, KIND_RIGHT: begin
                    n_valid = 1'b1;
                end
                KIND_CV0: begin
                    n_cv0_sum = r_cv0_sum + sample_ext;
                end
                KIND_CV1: begin
                    if (r_frame == LAST_FRAME) begin
                        // Block end: hand both totals on and start over.
                        n_valid      = 1'b1;
                        n_item.is_cv = 1'b1;
                        n_item.audio = '0;
                        n_sum0       = r_cv0_sum;
                        n_sum1       = r_cv1_sum + sample_ext;
                        n_cv0_sum    = '0;
                        n_cv1_sum    = '0;
                        n_frame      = '0;
                    end else begin
                        n_cv1_sum = r_cv1_sum + sample_ext;
                        n_frame   = r_frame + FW'(1);
                    end
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= KIND_LEFT;
            r_frame   <= '0;
            r_cv0_sum <= '0;
            r_cv1_sum <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_slot    <= n_slot;
            r_frame   <= n_frame;
            r_cv0_sum <= n_cv0_sum;
            r_cv1_sum <= n_cv1_sum;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_sum0 <= n_sum0;
        r_sum1 <= n_sum1;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_sum0  = r_sum0;
    assign o_sum1  = r_sum1;

endmodule

>>> rtl/core/adcdi_scale.sv
// Two-stage CV scaling: block average, then inversion, gain and saturation.
module adcdi_scale #(
    parameter int FRAMES_PER_BLOCK = adcdi_pkg::DEFAULT_FRAMES,
    parameter int SUM_W            = adcdi_pkg::ADC_W + $clog2(FRAMES_PER_BLOCK)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [adcdi_pkg::GAIN_W-1:0] i_gain,
    input  logic                         i_valid,
    input  adcdi_pkg::t_item             i_item,
    input  logic [SUM_W-1:0]             i_sum0,
    input  logic [SUM_W-1:0]             i_sum1,
    output logic                         o_ready,
    output logic                         o_valid,
    output adcdi_pkg::t_pair             o_pair,
    input  logic                         i_ready
);
    import adcdi_pkg::*;

    // The average is (sum >> 2) / FRAMES_PER_BLOCK, done as a multiply by a
    // rounded-up reciprocal; the shift is chosen so the quotient is exact over
    // the whole range of the quarter sum.
    localparam int FRAME_L = $clog2(FRAMES_PER_BLOCK);
    localparam int QW      = SUM_W - 2;
    localparam int SHIFT   = QW + FRAME_L;
    localparam int MW      = QW + 1;
    localparam int PW      = QW + MW;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(FRAMES_PER_BLOCK) - 64'd1) / 64'(FRAMES_PER_BLOCK);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];
    localparam int GPW = CV_W + GAIN_W;

    logic            r2_valid, r3_valid;
    t_item           r2_item, r3_item;
    logic [CV_W-1:0] r2_avg0, r2_avg1;
    logic [CV_W-1:0] r3_cv0, r3_cv1;
    logic            stage3_ready;
    logic [PW-1:0]   avg_prod0, avg_prod1;
    logic [CV_W-1:0] n_cv0, n_cv1;

    assign stage3_ready = !r3_valid || i_ready;
    assign o_ready      = !r2_valid || stage3_ready;

    assign avg_prod0 = PW'(i_sum0[SUM_W-1:2]) * PW'(RECIP);
    assign avg_prod1 = PW'(i_sum1[SUM_W-1:2]) * PW'(RECIP);

    function automatic logic [CV_W-1:0] gain_sat(input logic [CV_W-1:0] avg,
                                                 input logic [GAIN_W-1:0] gain);
        logic [GPW-1:0]                  prod;
        logic [GPW-GAIN_SHIFT-1:0]       scaled;
        prod   = GPW'(CV_FULL ^ avg) * GPW'(gain);
        scaled = prod[GPW-1:GAIN_SHIFT];
        return (scaled > (GPW-GAIN_SHIFT)'(CV_FULL)) ? CV_FULL : scaled[CV_W-1:0];
    endfunction

    assign n_cv0 = gain_sat(r2_avg0, i_gain);
    assign n_cv1 = gain_sat(r2_avg1, i_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r2_valid <= i_valid;
            end
            if (stage3_ready) begin
                r3_valid <= r2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r2_item <= i_item;
            r2_avg0 <= avg_prod0[SHIFT +: CV_W];
            r2_avg1 <= avg_prod1[SHIFT +: CV_W];
        end
        if (stage3_ready) begin
            r3_item <= r2_item;
            r3_cv0  <= n_cv0;
            r3_cv1  <= n_cv1;
        end
    end

    assign o_valid     = r3_valid;
    assign o_pair.item = r3_item;
    assign o_pair.cv0  = r3_cv0;
    assign o_pair.cv1  = r3_cv1;

endmodule

>>> rtl/core/adcdi_out.sv
// Output register that sends one word per audio item and two per CV block.
module adcdi_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  adcdi_pkg::t_pair              i_pair,
    output logic                          o_ready,
    output logic                          o_valid,
    output adcdi_pkg::t_kind              o_kind,
    output logic [adcdi_pkg::AUDIO_W-1:0] o_audio,
    output logic [adcdi_pkg::CV_W-1:0]    o_cv,
    output logic                          o_last,
    input  logic                          i_ready
);
    import adcdi_pkg::*;

    logic  r_valid;
    logic  r_second;
    t_pair r_pair;
    logic  word_done;

    // A CV pair goes out as control voltage 0 first, then control voltage 1.
    always_comb begin
        if (!r_pair.item.is_cv) begin
            o_kind  = r_pair.item.kind;
            o_audio = r_pair.item.audio;
            o_cv    = '0;
            o_last  = 1'b1;
        end else begin
            o_kind  = r_second ? KIND_CV1 : KIND_CV0;
            o_audio = '0;
            o_cv    = r_second ? r_pair.cv1 : r_pair.cv0;
            o_last  = r_second;
        end
    end

    assign word_done = r_valid && i_ready;
    assign o_ready   = !r_valid || (i_ready && o_last);
    assign o_valid   = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (o_ready) begin
            r_valid  <= i_valid;
            r_second <= 1'b0;
        end else if (word_done) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pair <= i_pair;
        end
    end

endmodule

>>> rtl/core/adc_deinterleave_cv_average_unit.sv
// Top level of the ADC deinterleave and CV boxcar averaging block.
//
// Conversion words arrive in a repeating four-slot frame: audio left, audio
// right, control voltage 0, control voltage 1. Each audio word becomes a
// signed 16-bit sample and leaves as a single word with tlast set. The CV
// words are summed over FRAMES_PER_BLOCK frames; after the last CV word of a
// block, two words follow (CV 0 with tlast low, then CV 1 with tlast high),
// each the block average inverted against 0xfff, scaled by cv_gain, shifted
// right by eight and saturated to 4095. The block accepts one conversion word
// per clock while the output side keeps up; each result is registered in the
// front, scaling and output stages. A block end needs two output words, which
// the frame's silent CV 0 slot absorbs, so the sustained rate stays one word
// per clock while the output side keeps up. After reset the block is ready at
// once; cv_gain resets to 261 and sits at byte address 0 of the APB port.
module adc_deinterleave_cv_average_unit #(
    parameter int FRAMES_PER_BLOCK = adcdi_pkg::DEFAULT_FRAMES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [13:0] adc_sample, [15:14] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] audio_sample, [27:16] cv_value, [31:28] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import adcdi_pkg::*;

    localparam int SUM_W = ADC_W + $clog2(FRAMES_PER_BLOCK);

    logic [GAIN_W-1:0]  r_cv_gain;
    logic               cfg_write;

    logic               front_valid, front_ready;
    t_item              front_item;
    logic [SUM_W-1:0]   front_sum0, front_sum1;
    logic               scale_valid, scale_ready;
    t_pair              scale_pair;
    t_kind              out_kind;
    logic [AUDIO_W-1:0] out_audio;
    logic [CV_W-1:0]    out_cv;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CV_GAIN);
    assign prdata    = (paddr[2] == REG_CV_GAIN) ? 32'(r_cv_gain) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_gain <= GAIN_RESET;
        end else if (cfg_write) begin
            r_cv_gain <= pwdata[GAIN_W-1:0];
        end
    end

    adcdi_front #(
        .FRAMES_PER_BLOCK (FRAMES_PER_BLOCK),
        .SUM_W            (SUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_sample (s_axis_tdata[ADC_W-1:0]),
        .o_ready  (s_axis_tready),
        .o_valid  (front_valid),
        .o_item   (front_item),
        .o_sum0   (front_sum0),
        .o_sum1   (front_sum1),
        .i_ready  (front_ready)
    );

    adcdi_scale #(
        .FRAMES_PER_BLOCK (FRAMES_PER_BLOCK),
        .SUM_W            (SUM_W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_cv_gain),
        .i_valid (front_valid),
        .i_item  (front_item),
        .i_sum0  (front_sum0),
        .i_sum1  (front_sum1),
        .o_ready (front_ready),
        .o_valid (scale_valid),
        .o_pair  (scale_pair),
        .i_ready (scale_ready)
    );

    adcdi_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (scale_valid),
        .i_pair  (scale_pair),
        .o_ready (scale_ready),
        .o_valid (m_axis_tvalid),
        .o_kind  (out_kind),
        .o_audio (out_audio),
        .o_cv    (out_cv),
        .o_last  (m_axis_tlast),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, out_cv, out_audio};
    assign m_axis_tuser = out_kind;

endmodule
